// File: src/i2cm_pkg.sv
// Package for the byte-transaction I2C master.
// Holds field widths, the bus phase encoding and shared constants.
// Depends on nothing; every other file uses it.
`default_nettype none

package i2cm_pkg;

    localparam int C_ADDR_W = 7;
    localparam int C_BYTE_W = 8;
    localparam int C_WORD_W = 16;
    localparam int C_BIT_W  = 4;

    localparam logic [C_BYTE_W-1:0] C_MSB_MASK  = 8'h80;
    localparam logic [C_BYTE_W-1:0] C_TPD_RESET = 8'd1;
    localparam logic [C_BIT_W-1:0]  C_BITS_PER_BYTE = 4'd8;

    localparam logic C_OP_WRITE = 1'b0;
    localparam logic C_OP_READ  = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST1  = 5'd1,
        PH_ST2  = 5'd2,
        PH_AB_L = 5'd3,
        PH_AB_H = 5'd4,
        PH_AK_L = 5'd5,
        PH_AK_H = 5'd6,
        PH_DB_L = 5'd7,
        PH_DB_H = 5'd8,
        PH_DK_L = 5'd9,
        PH_DK_H = 5'd10,
        PH_R1_L = 5'd11,
        PH_R1_H = 5'd12,
        PH_M1_L = 5'd13,
        PH_M1_H = 5'd14,
        PH_R2_L = 5'd15,
        PH_R2_H = 5'd16,
        PH_M2_L = 5'd17,
        PH_M2_H = 5'd18,
        PH_SP1  = 5'd19,
        PH_SP2  = 5'd20,
        PH_SP3  = 5'd21
    } t_phase;

endpackage

`default_nettype wire

// File: src/i2cm_intf.sv
// Channel interfaces of the byte-transaction I2C master: tick input,
// result output and configuration write. Each has valid, ready and payload.
// Depends on i2cm_pkg for the field widths.
`default_nettype none

interface i2cm_tick_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd_valid;
    logic                          opcode;
    logic [i2cm_pkg::C_ADDR_W-1:0] slave_addr;
    logic [i2cm_pkg::C_BYTE_W-1:0] write_data;
    logic                          sda_in;

    modport source (output valid, cmd_valid, opcode, slave_addr, write_data, sda_in,
                    input ready);
    modport sink   (input valid, cmd_valid, opcode, slave_addr, write_data, sda_in,
                    output ready);
endinterface

interface i2cm_res_if;
    logic                          valid;
    logic                          ready;
    logic                          scl;
    logic                          sda_out;
    logic                          sda_drive;
    logic                          busy_res;
    logic                          done_res;
    logic [i2cm_pkg::C_WORD_W-1:0] read_word;
    logic                          addr_nack;
    logic                          data_nack;

    modport source (output valid, scl, sda_out, sda_drive, busy_res, done_res,
                    read_word, addr_nack, data_nack, input ready);
    modport sink   (input valid, scl, sda_out, sda_drive, busy_res, done_res,
                    read_word, addr_nack, data_nack, output ready);
endinterface

interface i2cm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [i2cm_pkg::C_BYTE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: src/i2c_master_byte_transactions.sv
// Top level of the byte-transaction I2C master: bus sequencer and result register.
// Depends on i2cm_pkg and the channel interfaces in i2cm_intf.sv.
//
//   Channel | Direction | Moves per item
//   i_cmd   | in        | one bus tick: command fields and the sampled SDA level
//   o_res   | out       | SCL/SDA levels, busy/done flags, read word, nack flags
//   i_cfg   | in        | ticks_per_delay, always ready
//
// Every tick item is handled by the single combinational pass from the phase register to the
// result register; one item can be accepted per cycle while that register is not stalled.
// Reset is synchronous and active low: idle phase, all state zero, ticks_per_delay one,
// result register empty. A stalled result holds its register, and a new item is taken
// only when that register is empty or is being taken in the same cycle.
`default_nettype none

module i2c_master_byte_transactions (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2cm_tick_if.sink i_cmd,
    i2cm_res_if.source o_res,
    i2cm_cfg_if.sink  i_cfg
);
    import i2cm_pkg::*;

    // Transaction state, updated once per accepted tick.
    t_phase              r_phase, n_phase;
    logic [C_BIT_W-1:0]  r_bit_index, n_bit_index;
    logic [C_BYTE_W-1:0] r_shift_byte, n_shift_byte;
    logic [C_WORD_W-1:0] r_word_acc, n_word_acc;
    logic [C_BYTE_W-1:0] r_delay_count, n_delay_count;
    logic                r_is_read, n_is_read;
    logic [C_ADDR_W-1:0] r_held_addr, n_held_addr;
    logic [C_BYTE_W-1:0] r_held_data, n_held_data;
    logic [1:0]          r_nack_flags, n_nack_flags;
    logic [C_BYTE_W-1:0] r_tpd;

    // Result register.
    logic                r_out_valid;
    logic                r_scl, n_scl;
    logic                r_sda_out, n_sda_out;
    logic                r_sda_drive, n_sda_drive;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [C_WORD_W-1:0] r_read_word, n_read_word;
    logic                r_addr_nack, n_addr_nack;
    logic                r_data_nack, n_data_nack;

    logic                in_accept;
    logic                start_cmd;
    t_phase              cur_phase;
    logic [C_BYTE_W-1:0] cur_shift;
    logic [C_BIT_W-1:0]  cur_bit;
    logic [C_BIT_W-1:0]  bit_inc;
    logic [C_BYTE_W-1:0] eff_tpd;
    logic                seg_end;
    logic                wbit;

    assign in_accept   = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid     = r_out_valid;
    assign o_res.scl       = r_scl;
    assign o_res.sda_out   = r_sda_out;
    assign o_res.sda_drive = r_sda_drive;
    assign o_res.busy_res  = r_busy;
    assign o_res.done_res  = r_done;
    assign o_res.read_word = r_read_word;
    assign o_res.addr_nack = r_addr_nack;
    assign o_res.data_nack = r_data_nack;

    // A command is taken only from the idle phase; on that same tick the
    // first tick of the START segment goes out.
    assign start_cmd = (r_phase == PH_IDLE) && i_cmd.cmd_valid;
    assign cur_phase = start_cmd ? PH_ST1 : r_phase;
    assign cur_shift = start_cmd ? '0 : r_shift_byte;
    assign cur_bit   = start_cmd ? '0 : r_bit_index;
    assign bit_inc   = cur_bit + C_BIT_W'(1);
    assign wbit      = (cur_shift & C_MSB_MASK) != '0;

    // A delay of zero behaves as one tick per segment.
    assign eff_tpd = (r_tpd == '0) ? C_BYTE_W'(1) : r_tpd;
    assign seg_end = ({1'b0, (start_cmd ? '0 : r_delay_count)} + (C_BYTE_W+1)'(1))
                     >= {1'b0, eff_tpd};

    always_comb begin
        n_phase       = cur_phase;
        n_bit_index   = cur_bit;
        n_shift_byte  = cur_shift;
        n_word_acc    = start_cmd ? '0 : r_word_acc;
        n_delay_count = start_cmd ? '0 : r_delay_count;
        n_is_read     = start_cmd ? i_cmd.opcode : r_is_read;
        n_held_addr   = start_cmd ? i_cmd.slave_addr : r_held_addr;
        n_held_data   = start_cmd ? i_cmd.write_data : r_held_data;
        n_nack_flags  = start_cmd ? '0 : r_nack_flags;

        n_scl       = 1'b1;
        n_sda_out   = 1'b1;
        n_sda_drive = 1'b1;
        n_busy      = 1'b0;
        n_done      = 1'b0;

        if (cur_phase != PH_IDLE) begin
            n_busy = 1'b1;

            // Bus levels for the segment in progress. Released SDA reads as high.
            unique case (cur_phase)
                PH_ST2: n_sda_out = 1'b0;
                PH_AB_L, PH_DB_L: begin
                    n_scl     = 1'b0;
                    n_sda_out = wbit;
                end
                PH_AB_H, PH_DB_H: n_sda_out = wbit;
                PH_AK_L, PH_DK_L, PH_R1_L, PH_R2_L: begin
                    n_scl       = 1'b0;
                    n_sda_drive = 1'b0;
                end
                PH_AK_H, PH_DK_H, PH_R1_H, PH_R2_H: n_sda_drive = 1'b0;
                PH_M1_L, PH_SP1: begin
                    n_scl     = 1'b0;
                    n_sda_out = 1'b0;
                end
                PH_M1_H, PH_SP2: n_sda_out = 1'b0;
                PH_M2_L: n_scl = 1'b0;
                default: ;
            endcase

            if (seg_end) begin
                n_delay_count = '0;
                unique case (cur_phase)
                    PH_ST1: n_phase = PH_ST2;
                    PH_ST2: begin
                        n_shift_byte = {n_held_addr, n_is_read};
                        n_bit_index  = '0;
                        n_phase      = PH_AB_L;
                    end
                    PH_AB_L: n_phase = PH_AB_H;
                    PH_DB_L: n_phase = PH_DB_H;
                    PH_AB_H, PH_DB_H: begin
                        n_shift_byte = {cur_shift[C_BYTE_W-2:0], 1'b0};
                        n_bit_index  = bit_inc;
                        if (bit_inc >= C_BITS_PER_BYTE) begin
                            n_phase = (cur_phase == PH_AB_H) ? PH_AK_L : PH_DK_L;
                        end else begin
                            n_phase = (cur_phase == PH_AB_H) ? PH_AB_L : PH_DB_L;
                        end
                    end
                    PH_AK_L: n_phase = PH_AK_H;
                    PH_DK_L: n_phase = PH_DK_H;
                    PH_AK_H: begin
                        n_nack_flags[0] = i_cmd.sda_in;
                        n_bit_index     = '0;
                        if (n_is_read == C_OP_READ) begin
                            n_shift_byte = '0;
                            n_phase      = PH_R1_L;
                        end else begin
                            n_shift_byte = n_held_data;
                            n_phase      = PH_DB_L;
                        end
                    end
                    PH_DK_H: begin
                        n_nack_flags[1] = i_cmd.sda_in;
                        n_phase         = PH_SP1;
                    end
                    PH_R1_L: n_phase = PH_R1_H;
                    PH_R2_L: n_phase = PH_R2_H;
                    PH_R1_H, PH_R2_H: begin
                        n_shift_byte = {cur_shift[C_BYTE_W-2:0], i_cmd.sda_in};
                        n_bit_index  = bit_inc;
                        if (bit_inc >= C_BITS_PER_BYTE) begin
                            if (cur_phase == PH_R1_H) begin
                                n_word_acc[C_WORD_W-1:C_BYTE_W] = n_shift_byte;
                                n_phase = PH_M1_L;
                            end else begin
                                n_word_acc[C_BYTE_W-1:0] = n_shift_byte;
                                n_phase = PH_M2_L;
                            end
                        end else begin
                            n_phase = (cur_phase == PH_R1_H) ? PH_R1_L : PH_R2_L;
                        end
                    end
                    PH_M1_L: n_phase = PH_M1_H;
                    PH_M1_H: begin
                        n_shift_byte = '0;
                        n_bit_index  = '0;
                        n_phase      = PH_R2_L;
                    end
                    PH_M2_L: n_phase = PH_M2_H;
                    PH_M2_H: n_phase = PH_SP1;
                    PH_SP1:  n_phase = PH_SP2;
                    PH_SP2:  n_phase = PH_SP3;
                    PH_SP3: begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end else begin
                n_delay_count = n_delay_count + C_BYTE_W'(1);
            end
        end

        // Result fields are only reported together with done.
        n_read_word = n_done ? n_word_acc : '0;
        n_addr_nack = n_done && n_nack_flags[0];
        n_data_nack = n_done && n_nack_flags[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_index   <= '0;
            r_shift_byte  <= '0;
            r_word_acc    <= '0;
            r_delay_count <= '0;
            r_is_read     <= 1'b0;
            r_held_addr   <= '0;
            r_held_data   <= '0;
            r_nack_flags  <= '0;
        end else if (in_accept) begin
            r_phase       <= n_phase;
            r_bit_index   <= n_bit_index;
            r_shift_byte  <= n_shift_byte;
            r_word_acc    <= n_word_acc;
            r_delay_count <= n_delay_count;
            r_is_read     <= n_is_read;
            r_held_addr   <= n_held_addr;
            r_held_data   <= n_held_data;
            r_nack_flags  <= n_nack_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpd <= C_TPD_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_tpd <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_scl       <= n_scl;
            r_sda_out   <= n_sda_out;
            r_sda_drive <= n_sda_drive;
            r_busy      <= n_busy;
            r_done      <= n_done;
            r_read_word <= n_read_word;
            r_addr_nack <= n_addr_nack;
            r_data_nack <= n_data_nack;
        end
    end

`ifndef SYNTH
    // Done is only reported on a tick of a running transaction.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> r_busy)
        else $error("done reported outside a transaction");

    // An idle tick leaves the bus driven high on both lines.
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_busy) |-> (r_scl && r_sda_out && r_sda_drive))
        else $error("idle tick does not drive the bus high");

    // Result fields stay zero except with done.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_done) |-> (r_read_word == '0 && !r_addr_nack && !r_data_nack))
        else $error("result fields set without done");

    // After a done tick has been taken, the sequencer is idle again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_done) |=> (r_phase == PH_IDLE))
        else $error("sequencer not idle after stop");
`endif

endmodule

`default_nettype wire
